### src/msx_pkg.sv
package msx_pkg;

    localparam int unsigned DATA_WORDS_DEF = 256;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 1'd1;

    localparam logic [31:0] TEXT_BASE_RST = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_LINK = 5'd31;

    // Major opcodes.
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_JAL   = 6'd3;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_SLTIU = 6'd11;
    localparam logic [5:0] OP_ANDI  = 6'd12;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [5:0] OP_LUI   = 6'd15;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    // Function codes for the R-type opcode.
    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_NOR  = 6'd39;
    localparam logic [5:0] FN_SLTU = 6'd43;

    typedef struct packed {
        logic        inst_valid;
        logic [5:0]  opcode;
        logic [5:0]  funct;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  shamt;
        logic [15:0] immediate;
        logic [25:0] jump_target;
    } inst_t;

    typedef struct packed {
        logic        halted;
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic        load;
        logic        mem_hit;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
    } exec_t;

endpackage

### src/msx_exec.sv
module msx_exec #(
    parameter int unsigned DATA_WORDS = msx_pkg::DATA_WORDS_DEF
) (
    input  msx_pkg::inst_t                  inst,
    input  logic [31:0]                     a,
    input  logic [31:0]                     b,
    input  logic [31:0]                     pc,
    input  logic                            stopped,
    input  logic [31:0]                     imm_off,
    output msx_pkg::exec_t                  res,
    output logic [$clog2(DATA_WORDS)-1:0]   mem_index
);
    import msx_pkg::*;

    localparam int unsigned AW = $clog2(DATA_WORDS);

    logic [31:0] sext;
    logic [31:0] zext;
    logic [31:0] pc4;
    logic [31:0] br_target;
    logic [31:0] jmp_target;
    logic [31:0] maddr;
    logic [31:0] woff;
    logic        hit;
    logic        halt;
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        store;
    logic        load;

    assign sext       = {{16{inst.immediate[15]}}, inst.immediate};
    assign zext       = {16'd0, inst.immediate};
    assign pc4        = pc + 32'd4;
    assign br_target  = pc4 + {sext[29:0], 2'b00};
    assign jmp_target = {pc4[31:28], inst.jump_target, 2'b00};
    assign maddr      = a + sext;
    // imm_off already folds in the data base, so the word offset needs one add.
    assign woff       = a + imm_off;
    assign hit        = woff[31:2] < 30'(DATA_WORDS);
    assign mem_index  = woff[AW+1:2];
    assign halt       = stopped || !inst.inst_valid;

    always_comb
    begin
        npc   = pc4;
        wr    = 1'b0;
        widx  = inst.rd;
        wval  = '0;
        store = 1'b0;
        load  = 1'b0;
        unique case (inst.opcode)
            OP_RTYPE:
            begin
                unique case (inst.funct)
                    FN_ADDU: begin wr = 1'b1; wval = a + b; end
                    FN_AND:  begin wr = 1'b1; wval = a & b; end
                    FN_NOR:  begin wr = 1'b1; wval = ~(a | b); end
                    FN_OR:   begin wr = 1'b1; wval = a | b; end
                    FN_SLTU: begin wr = 1'b1; wval = {31'd0, a < b}; end
                    FN_SLL:  begin wr = 1'b1; wval = b << inst.shamt; end
                    FN_SRL:  begin wr = 1'b1; wval = b >> inst.shamt; end
                    FN_SUBU: begin wr = 1'b1; wval = a - b; end
                    FN_JR:   npc = a;
                    default: ;
                endcase
            end
            OP_J:     npc = jmp_target;
            OP_JAL:
            begin
                npc  = jmp_target;
                wr   = 1'b1;
                widx = REG_LINK;
                wval = pc4 + 32'd4;
            end
            OP_BEQ:   if (a == b) npc = br_target;
            OP_BNE:   if (a != b) npc = br_target;
            OP_ADDIU: begin wr = 1'b1; widx = inst.rt; wval = a + sext; end
            OP_SLTIU: begin wr = 1'b1; widx = inst.rt; wval = {31'd0, a < sext}; end
            OP_ANDI:  begin wr = 1'b1; widx = inst.rt; wval = a & zext; end
            OP_ORI:   begin wr = 1'b1; widx = inst.rt; wval = a | zext; end
            OP_LUI:   begin wr = 1'b1; widx = inst.rt; wval = {inst.immediate, 16'd0}; end
            OP_LW:    begin wr = 1'b1; widx = inst.rt; load = 1'b1; end
            OP_SW:    store = 1'b1;
            default:  ;
        endcase

        res = '0;
        if (halt)
        begin
            res.halted  = 1'b1;
            res.next_pc = pc;
        end
        else
        begin
            res.next_pc     = npc;
            res.reg_write   = wr && (widx != REG_ZERO);
            res.reg_index   = res.reg_write ? widx : REG_ZERO;
            // A load's value is filled in after the memory read.
            res.reg_value   = (res.reg_write && !load) ? wval : '0;
            res.mem_write   = store;
            res.load        = load;
            res.mem_hit     = hit;
            res.mem_address = (load || store) ? maddr : '0;
            res.mem_data    = store ? b : '0;
        end
    end

endmodule

### src/mips_subset_executor.sv
// Executes one decoded MIPS-32 integer instruction per input beat and returns one result
// beat for it. An instruction is taken in every clock while results keep flowing: the
// input register holds the operands read from the register file, one pass of execute
// logic settles the next PC, the write-back value and the memory access, and the result
// register presents the beat. Results are bypassed straight into the following
// instruction, so there is no hazard stall. After reset the data memory is cleared one
// word a cycle, which keeps the input stalled until every word is cleared; the
// configuration registers may be written during that time. Writing text_base also
// loads the PC. An input beat with inst_valid low halts the block; from then on every
// beat returns the halted result until the next reset.
module mips_subset_executor #(
    parameter int unsigned DATA_WORDS = msx_pkg::DATA_WORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_wr_en,
    input  logic [msx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             inst_valid,
    input  logic [5:0]                       opcode,
    input  logic [5:0]                       funct,
    input  logic [4:0]                       rs,
    input  logic [4:0]                       rt,
    input  logic [4:0]                       rd,
    input  logic [4:0]                       shamt,
    input  logic [15:0]                      immediate,
    input  logic [25:0]                      jump_target,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             halted,
    output logic [31:0]                      next_pc,
    output logic                             reg_write,
    output logic [4:0]                       reg_index,
    output logic [31:0]                      reg_value,
    output logic                             mem_write,
    output logic [31:0]                      mem_address,
    output logic [31:0]                      mem_data
);
    import msx_pkg::*;

    localparam int unsigned AW = $clog2(DATA_WORDS);

    logic [31:0] data_base_reg;
    logic [31:0] pc_reg;
    logic        stopped_reg;

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;

    logic [31:0] dmem [DATA_WORDS];
    logic [31:0] dmem_rdata_reg;

    logic        e_valid_reg;
    inst_t       e_inst_reg;
    logic [31:0] e_a_reg;
    logic [31:0] e_b_reg;
    logic [31:0] e_imm_off_reg;

    logic        w_valid_reg;
    exec_t       w_res_reg;
    logic        wb_pend_reg;

    inst_t         in_inst;
    logic          in_acc;
    logic          w_free;
    logic          e_adv;
    logic [31:0]   loaded;
    logic [31:0]   wb_value;
    logic          wb_en;
    logic [31:0]   op_a;
    logic [31:0]   op_b;
    exec_t         ex;
    logic [AW-1:0] ex_index;

    assign in_inst = '{inst_valid:  inst_valid,
                       opcode:      opcode,
                       funct:       funct,
                       rs:          rs,
                       rt:          rt,
                       rd:          rd,
                       shamt:       shamt,
                       immediate:   immediate,
                       jump_target: jump_target};

    assign w_free   = !w_valid_reg || !out_stall;
    assign e_adv    = e_valid_reg && w_free;
    assign in_stall = clr_busy_reg || (e_valid_reg && !w_free);
    assign in_acc   = in_valid && !in_stall;

    assign loaded   = w_res_reg.mem_hit ? dmem_rdata_reg : '0;
    assign wb_value = (w_res_reg.load && w_res_reg.reg_write) ? loaded : w_res_reg.reg_value;
    // The register file is written in the cycle after a beat lands in the result register.
    assign wb_en    = wb_pend_reg && w_res_reg.reg_write;

    // The result register always holds the newest retired instruction, so it forwards.
    assign op_a = (w_valid_reg && w_res_reg.reg_write && w_res_reg.reg_index == e_inst_reg.rs)
                  ? wb_value : e_a_reg;
    assign op_b = (w_valid_reg && w_res_reg.reg_write && w_res_reg.reg_index == e_inst_reg.rt)
                  ? wb_value : e_b_reg;

    msx_exec #(
        .DATA_WORDS (DATA_WORDS)
    ) u_exec (
        .inst      (e_inst_reg),
        .a         (op_a),
        .b         (op_b),
        .pc        (pc_reg),
        .stopped   (stopped_reg),
        .imm_off   (e_imm_off_reg),
        .res       (ex),
        .mem_index (ex_index)
    );

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_base_reg <= DATA_BASE_RST;
            pc_reg        <= TEXT_BASE_RST;
            stopped_reg   <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            rf_valid_reg  <= '0;
            e_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            wb_pend_reg   <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DATA_WORDS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_TEXT_BASE)
                begin
                    pc_reg <= cfg_data;
                end
                else
                begin
                    data_base_reg <= cfg_data;
                end
            end
            else if (e_adv)
            begin
                pc_reg <= ex.next_pc;
                if (ex.halted)
                begin
                    stopped_reg <= 1'b1;
                end
            end

            if (wb_en)
            begin
                rf_valid_reg[w_res_reg.reg_index] <= 1'b1;
            end

            if (in_acc)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_adv)
            begin
                e_valid_reg <= 1'b0;
            end

            if (e_adv)
            begin
                w_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                w_valid_reg <= 1'b0;
            end
            wb_pend_reg <= e_adv;
        end
    end

    // Register file and the input register that captures its read data.
    always_ff @(posedge clk)
    begin
        if (wb_en)
        begin
            rf_mem[w_res_reg.reg_index] <= wb_value;
        end
        if (in_acc)
        begin
            e_inst_reg    <= in_inst;
            e_imm_off_reg <= {{16{immediate[15]}}, immediate} - data_base_reg;
            if (wb_en && w_res_reg.reg_index == rs)
            begin
                e_a_reg <= wb_value;
            end
            else
            begin
                e_a_reg <= rf_valid_reg[rs] ? rf_mem[rs] : '0;
            end
            if (wb_en && w_res_reg.reg_index == rt)
            begin
                e_b_reg <= wb_value;
            end
            else
            begin
                e_b_reg <= rf_valid_reg[rt] ? rf_mem[rt] : '0;
            end
        end
    end

    // Data memory and the result register.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            dmem[clr_addr_reg] <= '0;
        end
        else if (e_adv && ex.mem_write && ex.mem_hit)
        begin
            dmem[ex_index] <= ex.mem_data;
        end
        if (e_adv && ex.load && ex.mem_hit)
        begin
            dmem_rdata_reg <= dmem[ex_index];
        end
        if (e_adv)
        begin
            w_res_reg <= ex;
        end
    end

    assign out_valid   = w_valid_reg;
    assign halted      = w_res_reg.halted;
    assign next_pc     = w_res_reg.next_pc;
    assign reg_write   = w_res_reg.reg_write;
    assign reg_index   = w_res_reg.reg_index;
    assign reg_value   = wb_value;
    assign mem_write   = w_res_reg.mem_write;
    assign mem_address = w_res_reg.mem_address;
    assign mem_data    = w_res_reg.load ? loaded : w_res_reg.mem_data;

`ifndef SYNTHESIS
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wb_en |-> w_res_reg.reg_index != REG_ZERO)
        else $error("register zero written");

    a_no_exec_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !e_valid_reg)
        else $error("instruction executing during memory clear");

    a_retire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        e_adv |=> w_valid_reg && wb_pend_reg)
        else $error("retired instruction lost");

    a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !e_adv && !cfg_wr_en |=> $stable(pc_reg))
        else $error("PC changed without a retire");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        w_valid_reg && w_res_reg.halted |-> stopped_reg)
        else $error("halted beat without stopped state");
`endif

endmodule

### dv/msx_exec_checker.sv
`timescale 1ns / 100ps

module msx_exec_checker #(
    parameter int unsigned DATA_WORDS = msx_pkg::DATA_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [msx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,

    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          inst_valid,
    input  logic [5:0]                    opcode,
    input  logic [5:0]                    funct,
    input  logic [4:0]                    rs,
    input  logic [4:0]                    rt,
    input  logic [4:0]                    rd,
    input  logic [4:0]                    shamt,
    input  logic [15:0]                   immediate,
    input  logic [25:0]                   jump_target,

    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          halted,
    input  logic [31:0]                   next_pc,
    input  logic                          reg_write,
    input  logic [4:0]                    reg_index,
    input  logic [31:0]                   reg_value,
    input  logic                          mem_write,
    input  logic [31:0]                   mem_address,
    input  logic [31:0]                   mem_data,

    output int unsigned                   errors,
    output int unsigned                   pending,
    output int unsigned                   results_seen
);
    import msx_pkg::*;

    typedef struct packed {
        logic        halted;
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
    } retire_t;

    logic [31:0] gpr [32];
    logic [31:0] dmem [DATA_WORDS];
    logic [31:0] pc;
    logic [31:0] text_base;
    logic [31:0] data_base;
    logic        stopped;

    retire_t     retired_q [$];

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 50)
                $display("%0t: %s expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Executes one instruction against the shadow state and returns its result beat.
    task automatic retire_inst(input inst_t i, output retire_t r);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] simm;
        logic [31:0] npc;
        logic [31:0] wval;
        logic [31:0] word;
        logic [4:0]  widx;
        logic        wr;

        a    = gpr[i.rs];
        b    = gpr[i.rt];
        simm = {{16{i.immediate[15]}}, i.immediate};
        npc  = pc + 32'd4;
        wr   = 1'b0;
        widx = REG_ZERO;
        wval = '0;
        r    = '0;

        if (stopped || !i.inst_valid)
        begin
            stopped   = 1'b1;
            r.halted  = 1'b1;
            r.next_pc = pc;
        end
        else
        begin
            case (i.opcode)
                OP_RTYPE:
                begin
                    case (i.funct)
                        FN_ADDU: begin wr = 1'b1; widx = i.rd; wval = a + b; end
                        FN_SUBU: begin wr = 1'b1; widx = i.rd; wval = a - b; end
                        FN_AND:  begin wr = 1'b1; widx = i.rd; wval = a & b; end
                        FN_OR:   begin wr = 1'b1; widx = i.rd; wval = a | b; end
                        FN_NOR:  begin wr = 1'b1; widx = i.rd; wval = ~(a | b); end
                        FN_SLTU: begin wr = 1'b1; widx = i.rd; wval = {31'd0, a < b}; end
                        FN_SLL:  begin wr = 1'b1; widx = i.rd; wval = b << i.shamt; end
                        FN_SRL:  begin wr = 1'b1; widx = i.rd; wval = b >> i.shamt; end
                        FN_JR:   npc = a;
                        default: ;
                    endcase
                end
                OP_J:
                    npc = {npc[31:28], i.jump_target, 2'b00};
                OP_JAL:
                begin
                    wr   = 1'b1;
                    widx = REG_LINK;
                    wval = pc + 32'd8;
                    npc  = {npc[31:28], i.jump_target, 2'b00};
                end
                OP_BEQ:
                    if (a == b)
                        npc = npc + (simm << 2);
                OP_BNE:
                    if (a != b)
                        npc = npc + (simm << 2);
                OP_ADDIU: begin wr = 1'b1; widx = i.rt; wval = a + simm; end
                OP_SLTIU: begin wr = 1'b1; widx = i.rt; wval = {31'd0, a < simm}; end
                OP_ANDI:  begin wr = 1'b1; widx = i.rt; wval = a & {16'd0, i.immediate}; end
                OP_ORI:   begin wr = 1'b1; widx = i.rt; wval = a | {16'd0, i.immediate}; end
                OP_LUI:   begin wr = 1'b1; widx = i.rt; wval = {i.immediate, 16'd0}; end
                OP_LW:
                begin
                    r.mem_address = a + simm;
                    word          = (r.mem_address - data_base) >> 2;
                    r.mem_data    = (word < DATA_WORDS) ? dmem[word] : '0;
                    wr            = 1'b1;
                    widx          = i.rt;
                    wval          = r.mem_data;
                end
                OP_SW:
                begin
                    r.mem_address = a + simm;
                    r.mem_data    = b;
                    r.mem_write   = 1'b1;
                    word          = (r.mem_address - data_base) >> 2;
                    if (word < DATA_WORDS)
                        dmem[word] = b;
                end
                default: ;
            endcase

            // Register zero stays zero; the beat then reports no write at all.
            if (wr && widx == REG_ZERO)
                wr = 1'b0;
            if (wr)
                gpr[widx] = wval;
            pc          = npc;
            r.next_pc   = npc;
            r.reg_write = wr;
            r.reg_index = wr ? widx : REG_ZERO;
            r.reg_value = wr ? wval : '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        retire_t want;
        inst_t   cur;

        if (!rst_n)
        begin
            for (int k = 0; k < 32; k++)
                gpr[k] = '0;
            for (int k = 0; k < DATA_WORDS; k++)
                dmem[k] = '0;
            text_base = TEXT_BASE_RST;
            data_base = DATA_BASE_RST;
            pc        = TEXT_BASE_RST;
            stopped   = 1'b0;
            retired_q.delete();
            errors       = 0;
            results_seen = 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_TEXT_BASE)
                begin
                    text_base = cfg_data;
                    pc        = cfg_data;
                end
                else if (cfg_index == CFG_DATA_BASE)
                    data_base = cfg_data;
            end

            if (in_valid && !in_stall)
            begin
                cur = {inst_valid, opcode, funct, rs, rt, rd, shamt, immediate, jump_target};
                retire_inst(cur, want);
                retired_q.push_back(want);
            end

            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (retired_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 50)
                        $display("%0t: result beat with no instruction outstanding, next_pc %h",
                                 $time, next_pc);
                end
                else
                begin
                    want = retired_q.pop_front();
                    check_field("halted", 32'(want.halted), 32'(halted));
                    check_field("next_pc", want.next_pc, next_pc);
                    check_field("reg_write", 32'(want.reg_write), 32'(reg_write));
                    check_field("reg_index", 32'(want.reg_index), 32'(reg_index));
                    check_field("reg_value", want.reg_value, reg_value);
                    check_field("mem_write", 32'(want.mem_write), 32'(mem_write));
                    check_field("mem_address", want.mem_address, mem_address);
                    check_field("mem_data", want.mem_data, mem_data);
                end
            end

            pending <= retired_q.size();
        end
    end

endmodule

### dv/mips_subset_executor_tb.sv
`timescale 1ns / 100ps

module mips_subset_executor_tb;

    import msx_pkg::*;

    localparam logic [4:0] REG_GP     = 5'd28;
    localparam logic [5:0] FN_UNUSED  = 6'd1;
    localparam logic [5:0] OP_UNUSED  = 6'd63;
    localparam int         PHASES     = 4;
    localparam int         PHASE_LEN  = 300;

    localparam logic [5:0] ALU_FN [9] = '{FN_SLL, FN_SRL, FN_JR, FN_ADDU, FN_SUBU,
                                          FN_AND, FN_OR, FN_NOR, FN_SLTU};
    localparam logic [5:0] MAJOR_OP [9] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU,
                                            OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI};

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [31:0]          cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic                 inst_valid  = 1'b0;
    logic [5:0]           opcode      = '0;
    logic [5:0]           funct       = '0;
    logic [4:0]           rs          = '0;
    logic [4:0]           rt          = '0;
    logic [4:0]           rd          = '0;
    logic [4:0]           shamt       = '0;
    logic [15:0]          immediate   = '0;
    logic [25:0]          jump_target = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 halted;
    logic [31:0]          next_pc;
    logic                 reg_write;
    logic [4:0]           reg_index;
    logic [31:0]          reg_value;
    logic                 mem_write;
    logic [31:0]          mem_address;
    logic [31:0]          mem_data;

    int unsigned          errors;
    int unsigned          pending;
    int unsigned          results_seen;

    logic                 steady = 1'b0;
    logic [31:0]          cur_data_base;
    int unsigned          n_items = 0;

    mips_subset_executor u_dut (.*);

    msx_exec_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 32);

    initial
    begin
        #2_000_000;
        $display("Timeout waiting for the pipeline to drain");
        $display("Test completed with failures");
        $finish;
    end

    function automatic inst_t make_inst(logic [5:0] op, logic [5:0] fn, logic [4:0] s,
                                        logic [4:0] t, logic [4:0] d, logic [4:0] sh,
                                        logic [15:0] imm, logic [25:0] tgt);
        return {1'b1, op, fn, s, t, d, sh, imm, tgt};
    endfunction

    function automatic inst_t rand_fields();
        logic [95:0] bits;
        inst_t       i;

        bits = {$urandom, $urandom, $urandom};
        i = bits[$bits(inst_t)-1:0];
        i.inst_valid = 1'b1;
        return i;
    endfunction

    task automatic issue(input inst_t i);
        if (!steady && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        inst_valid  <= i.inst_valid;
        opcode      <= i.opcode;
        funct       <= i.funct;
        rs          <= i.rs;
        rt          <= i.rt;
        rd          <= i.rd;
        shamt       <= i.shamt;
        immediate   <= i.immediate;
        jump_target <= i.jump_target;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        n_items++;
    endtask

    // Pending is registered in the checker, so it is read in the cycle after the last beat.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_bases(input logic [31:0] text, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TEXT_BASE;
        cfg_data  <= text;
        @(posedge clk);
        cfg_index <= CFG_DATA_BASE;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_data_base = data;
    endtask

    // Mostly legal instructions with random operands; loads and stores are preceded by
    // a lui/ori pair that points the base register into the data window.
    task automatic random_phase(input int count, input logic calm);
        inst_t       i;
        int          issued;
        int          k;
        int          word;
        int          off;
        logic [31:0] gp_val;

        issued = 0;
        while (issued < count)
        begin
            steady <= calm && issued >= 100 && issued < 250;
            i = rand_fields();
            k = $urandom_range(99);
            if (k < 8)
                issue(i);
            else if (k < 28)
            begin
                word   = ($urandom_range(1) != 0) ? $urandom_range(15)
                                                  : $urandom_range(DATA_WORDS_DEF - 1);
                gp_val = cur_data_base + 32'(word * 4);
                issue(make_inst(OP_LUI, i.funct, i.rs, REG_GP, i.rd, i.shamt,
                                gp_val[31:16], i.jump_target));
                issue(make_inst(OP_ORI, i.funct, REG_GP, REG_GP, i.rd, i.shamt,
                                gp_val[15:0], i.jump_target));
                i.opcode = ($urandom_range(1) != 0) ? OP_LW : OP_SW;
                i.rs     = REG_GP;
                if ($urandom_range(99) < 80)
                begin
                    off = int'($urandom_range(DATA_WORDS_DEF - 1)) - word;
                    i.immediate = 16'(off * 4 + int'($urandom_range(3)));
                end
                issue(i);
                issued += 3;
            end
            else
            begin
                k = $urandom_range(17);
                if (k < 9)
                begin
                    i.opcode = OP_RTYPE;
                    i.funct  = ALU_FN[k];
                end
                else
                    i.opcode = MAJOR_OP[k - 9];
                if ((i.opcode == OP_BEQ || i.opcode == OP_BNE) && $urandom_range(99) < 30)
                    i.rt = i.rs;
                issue(i);
                issued++;
            end
        end
        steady <= 1'b0;
    endtask

    initial
    begin
        inst_t i;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operand extremes, every operation but j, register zero, memory edges.
        set_bases(TEXT_BASE_RST, DATA_BASE_RST);
        issue(make_inst(OP_LUI,    '0,        0,  1,  0,  0, 16'hFFFF, '0));
        issue(make_inst(OP_ORI,    '0,        1,  1,  0,  0, 16'hFFFF, '0));
        issue(make_inst(OP_ADDIU,  '0,        0,  2,  0,  0, 16'h8000, '0));
        issue(make_inst(OP_ADDIU,  '0,        0,  3,  0,  0, 16'h7FFF, '0));
        issue(make_inst(OP_RTYPE,  FN_ADDU,   1,  3,  4,  0, '0, '0));
        issue(make_inst(OP_RTYPE,  FN_SUBU,   0,  1,  5,  0, '0, '0));
        issue(make_inst(OP_RTYPE,  FN_AND,    1,  2,  6,  0, '0, '0));
        issue(make_inst(OP_RTYPE,  FN_OR,     2,  3,  7,  0, '0, '0));
        issue(make_inst(OP_RTYPE,  FN_NOR,    0,  0,  8,  0, '0, '0));
        issue(make_inst(OP_RTYPE,  FN_SLTU,   3,  1,  9,  0, '0, '0));
        issue(make_inst(OP_SLTIU,  '0,        3, 10,  0,  0, 16'h8000, '0));
        issue(make_inst(OP_RTYPE,  FN_SLL,    0,  1, 11, 31, '0, '0));
        issue(make_inst(OP_RTYPE,  FN_SRL,    0,  1, 12, 31, '0, '0));
        issue(make_inst(OP_ANDI,   '0,        1, 13,  0,  0, 16'h8001, '0));
        issue(make_inst(OP_RTYPE,  FN_ADDU,   1,  1, REG_ZERO, 0, '0, '0));
        issue(make_inst(OP_LUI,    '0,        0, REG_GP, 0, 0, DATA_BASE_RST[31:16], '0));
        issue(make_inst(OP_SW,     '0,   REG_GP,  1,  0,  0, 16'h03FC, '0));
        issue(make_inst(OP_LW,     '0,   REG_GP, 14,  0,  0, 16'h03FC, '0));
        issue(make_inst(OP_SW,     '0,   REG_GP,  2,  0,  0, 16'h0400, '0));
        issue(make_inst(OP_LW,     '0,   REG_GP, 15,  0,  0, 16'hFFFC, '0));
        issue(make_inst(OP_BEQ,    '0,        0,  0,  0,  0, 16'h8000, '0));
        issue(make_inst(OP_BNE,    '0,        1,  0,  0,  0, 16'h7FFF, '0));
        issue(make_inst(OP_JAL,    '0,        0,  0,  0,  0, '0, 26'h3FF_FFFF));
        issue(make_inst(OP_RTYPE,  FN_JR,     1,  0,  0,  0, '0, '0));
        issue(make_inst(OP_RTYPE,  FN_UNUSED, 1,  2,  3,  0, '0, '0));
        issue(make_inst(OP_UNUSED, '0,        1,  2,  3,  0, 16'hFFFF, 26'h3FF_FFFF));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_bases('0, '0);
                1: set_bases(32'hFFFF_FFFC, 32'hFFFF_FFFC);
                2: set_bases($urandom & 32'hFFFF_FFFC, $urandom & 32'hFFFF_FFFC);
                default: set_bases(32'hEFFF_FFF0, DATA_BASE_RST);
            endcase
            random_phase(PHASE_LEN, p == 2);
            if (p == PHASES - 1)
            begin
                // Halt, then show that later beats keep returning the halted result.
                i = rand_fields();
                i.inst_valid = 1'b0;
                issue(i);
                repeat (3) issue(rand_fields());
            end
            drain();
        end

        $display("Checked %0d result beats for %0d instructions across %0d base settings,",
                 results_seen, n_items, PHASES + 1);
        $display("covering every operation, memory window edges and the halt state.");
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
src/msx_pkg.sv
src/msx_exec.sv
src/mips_subset_executor.sv
dv/msx_exec_checker.sv
dv/mips_subset_executor_tb.sv
